/* hw/rtl/fpsa_pkg.sv */
// ============================================================================
// fpsa_pkg
// Shared types, codes and sizes for the fit-policy segment allocator.
// ============================================================================
package fpsa_pkg;

    localparam int ADDR_BITS        = 16;
    localparam int FREE_ENTRIES_DEF = 32;
    localparam int USED_ENTRIES_DEF = 32;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_ADDR_W       = 3;
    localparam int POLICY_W         = 2;

    localparam logic [ADDR_BITS-1:0] POOL_SIZE_RST = 16'd4096;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // placement rules
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_POOL_SIZE  = 1'b0;
    localparam logic REG_FIT_POLICY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_BAD_BASE = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARD,
        S_ACHK,
        S_ADEC,
        S_FRD,
        S_FCHK,
        S_SRD,
        S_SWR,
        S_RESP
    } seq_state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] pool_size;
        logic [POLICY_W-1:0]  fit_policy;
        logic                 pool_wr;
    } cfg_t;

endpackage

/* hw/rtl/fpsa_if.sv */
// ============================================================================
// fpsa_if
// Valid/ready channels for command beats and result beats.
// ============================================================================
interface fpsa_cmd_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [fpsa_pkg::ADDR_BITS-1:0] req_size;
    logic [fpsa_pkg::ADDR_BITS-1:0] block_addr;

    modport source (output valid, output cmd, output req_size, output block_addr,
                    input ready);
    modport sink   (input valid, input cmd, input req_size, input block_addr,
                    output ready);
endinterface

interface fpsa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [fpsa_pkg::ADDR_BITS-1:0] granted_addr;

    modport source (output valid, output status, output granted_addr, input ready);
    modport sink   (input valid, input status, input granted_addr, output ready);
endinterface

/* hw/rtl/fit_policy_segment_allocator.sv */
// ============================================================================
// fit_policy_segment_allocator
// Segment allocator with first/best/worst fit over a free table and an
// allocated table, each held in a synchronous RAM.
// ============================================================================
//  channel   dir  beat contents                       handshake
//  command   in   cmd, req_size, block_addr           valid/ready
//  result    out  status, granted_addr                valid/ready
//  apb       in   pool_size @0x0, fit_policy @0x4     psel/penable, pready=1
//
//  Search: allocate walks the free table (first fit stops early), free walks
//  the allocated table; a zero request or unused policy code answers with no search.
//  Each table entry is read, then checked or moved, on the RAM port.
//  Reset: no clearing pass; a flag makes free entry 0 read as (0, pool_size)
//  until it is first written. Writing pool_size sets the flag again and resets both table counts.
//  Stalls: a command beat is taken only when the sequencer is idle; a result
//  waits in the output register while the next command is already being worked.
// ============================================================================
module fit_policy_segment_allocator #(
    parameter int FREE_ENTRIES = fpsa_pkg::FREE_ENTRIES_DEF,
    parameter int USED_ENTRIES = fpsa_pkg::USED_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    fpsa_cmd_if.sink                        command,
    fpsa_rsp_if.source                      result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpsa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fpsa_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fpsa_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int AB  = fpsa_pkg::ADDR_BITS;
    localparam int FIW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int UIW = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int UCW = $clog2(USED_ENTRIES + 1);
    localparam logic [FCW-1:0] FMAX = FCW'(FREE_ENTRIES);
    localparam logic [UCW-1:0] UMAX = UCW'(USED_ENTRIES);
    localparam logic [FCW-1:0] FONE = FCW'(1);
    localparam logic [UCW-1:0] UONE = UCW'(1);

    fpsa_pkg::cfg_t cfg;

    fpsa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer and counters
    fpsa_pkg::seq_state_t state_reg, state_next;
    logic [FCW-1:0] fcnt_reg;
    logic [UCW-1:0] ucnt_reg;
    logic [FCW-1:0] fidx_reg;
    logic [UCW-1:0] uidx_reg;
    logic [UCW-1:0] uidx_p1;
    logic           init_reg;     // free entry 0 still reads as (0, pool_size)
    logic           ch_vld_reg;
    logic           rsp_vld_reg;

    // beat payload
    logic                      cmd_reg;
    logic [AB-1:0]             req_reg;
    logic [AB-1:0]             addr_reg;
    logic [FIW-1:0]            ch_idx_reg;
    logic [AB-1:0]             ch_base_reg;
    logic [AB-1:0]             ch_len_reg;
    fpsa_pkg::status_t         pend_status_reg;
    logic [AB-1:0]             pend_addr_reg;
    fpsa_pkg::status_t         rsp_status_reg;
    logic [AB-1:0]             rsp_addr_reg;

    // RAM ports
    logic            f_rd_en, f_wr_en, u_rd_en, u_wr_en;
    logic [FIW-1:0]  f_rd_addr, f_wr_addr;
    logic [UIW-1:0]  u_rd_addr, u_wr_addr;
    logic [2*AB-1:0] f_wr_data, f_rd_data, u_wr_data, u_rd_data;

    fpsa_ram #(.WIDTH(2*AB), .DEPTH(FREE_ENTRIES), .AW(FIW)) u_free_ram (
        .clk     (clk),
        .wr_en   (f_wr_en),
        .wr_addr (f_wr_addr),
        .wr_data (f_wr_data),
        .rd_en   (f_rd_en),
        .rd_addr (f_rd_addr),
        .rd_data (f_rd_data)
    );

    fpsa_ram #(.WIDTH(2*AB), .DEPTH(USED_ENTRIES), .AW(UIW)) u_used_ram (
        .clk     (clk),
        .wr_en   (u_wr_en),
        .wr_addr (u_wr_addr),
        .wr_data (u_wr_data),
        .rd_en   (u_rd_en),
        .rd_addr (u_rd_addr),
        .rd_data (u_rd_data)
    );

    logic          acc;
    logic          rsp_load;
    logic [AB-1:0] seg_base, seg_len;
    logic          fits, take, u_match, alloc_ok, bad_req;

    assign command.ready = (state_reg == fpsa_pkg::S_IDLE);
    assign acc           = command.valid && command.ready;
    assign uidx_p1       = uidx_reg + UONE;
    assign rsp_load      = (state_reg == fpsa_pkg::S_RESP) && (!rsp_vld_reg || result.ready);
    assign bad_req       = (command.req_size == '0) ||
                           !(cfg.fit_policy inside {fpsa_pkg::POL_FIRST,
                                                    fpsa_pkg::POL_BEST,
                                                    fpsa_pkg::POL_WORST});

    // entry 0 override until its first write after reset or pool resize
    assign seg_base = (init_reg && fidx_reg == '0) ? '0 : f_rd_data[2*AB-1:AB];
    assign seg_len  = (init_reg && fidx_reg == '0) ? cfg.pool_size : f_rd_data[AB-1:0];
    assign fits     = (seg_len >= req_reg);
    assign take     = fits && (!ch_vld_reg ||
                      (cfg.fit_policy == fpsa_pkg::POL_BEST  && seg_len < ch_len_reg) ||
                      (cfg.fit_policy == fpsa_pkg::POL_WORST && seg_len > ch_len_reg));
    assign u_match  = (u_rd_data[2*AB-1:AB] == addr_reg);
    assign alloc_ok = ch_vld_reg && (ucnt_reg != UMAX);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpsa_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    if (command.cmd == fpsa_pkg::CMD_ALLOC)
                    begin
                        state_next = bad_req ? fpsa_pkg::S_RESP : fpsa_pkg::S_ARD;
                    end
                    else
                    begin
                        state_next = fpsa_pkg::S_FRD;
                    end
                end
            end
            fpsa_pkg::S_ARD:
            begin
                state_next = (fidx_reg == fcnt_reg) ? fpsa_pkg::S_ADEC : fpsa_pkg::S_ACHK;
            end
            fpsa_pkg::S_ACHK:
            begin
                state_next = (fits && cfg.fit_policy == fpsa_pkg::POL_FIRST) ?
                             fpsa_pkg::S_ADEC : fpsa_pkg::S_ARD;
            end
            fpsa_pkg::S_ADEC:
            begin
                state_next = fpsa_pkg::S_RESP;
            end
            fpsa_pkg::S_FRD:
            begin
                state_next = (uidx_reg == ucnt_reg) ? fpsa_pkg::S_RESP : fpsa_pkg::S_FCHK;
            end
            fpsa_pkg::S_FCHK:
            begin
                if (u_match)
                begin
                    state_next = (fcnt_reg == FMAX) ? fpsa_pkg::S_RESP : fpsa_pkg::S_SRD;
                end
                else
                begin
                    state_next = fpsa_pkg::S_FRD;
                end
            end
            fpsa_pkg::S_SRD:
            begin
                state_next = (uidx_p1 == ucnt_reg) ? fpsa_pkg::S_RESP : fpsa_pkg::S_SWR;
            end
            fpsa_pkg::S_SWR:
            begin
                state_next = fpsa_pkg::S_SRD;
            end
            fpsa_pkg::S_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = fpsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fpsa_pkg::S_IDLE;
            end
        endcase
    end

    // RAM controls
    always_comb
    begin
        f_rd_en   = 1'b0;
        f_wr_en   = 1'b0;
        u_rd_en   = 1'b0;
        u_wr_en   = 1'b0;
        f_rd_addr = fidx_reg[FIW-1:0];
        f_wr_addr = ch_idx_reg;
        f_wr_data = {ch_base_reg + req_reg, ch_len_reg - req_reg};
        u_rd_addr = uidx_reg[UIW-1:0];
        u_wr_addr = ucnt_reg[UIW-1:0];
        u_wr_data = {ch_base_reg, req_reg};
        case (state_reg)
            fpsa_pkg::S_ARD:
            begin
                f_rd_en = (fidx_reg != fcnt_reg);
            end
            fpsa_pkg::S_ADEC:
            begin
                f_wr_en = alloc_ok;
                u_wr_en = alloc_ok;
            end
            fpsa_pkg::S_FRD:
            begin
                u_rd_en = (uidx_reg != ucnt_reg);
            end
            fpsa_pkg::S_FCHK:
            begin
                // append to the free table
                f_wr_en   = u_match && (fcnt_reg != FMAX);
                f_wr_addr = fcnt_reg[FIW-1:0];
                f_wr_data = u_rd_data;
            end
            fpsa_pkg::S_SRD:
            begin
                u_rd_en   = (uidx_p1 != ucnt_reg);
                u_rd_addr = uidx_p1[UIW-1:0];
            end
            fpsa_pkg::S_SWR:
            begin
                // close the gap: entry i+1 moves down to i
                u_wr_en   = 1'b1;
                u_wr_addr = uidx_reg[UIW-1:0];
                u_wr_data = u_rd_data;
            end
            default:
            begin
                f_rd_en = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fpsa_pkg::S_IDLE;
            fcnt_reg    <= FONE;
            ucnt_reg    <= '0;
            fidx_reg    <= '0;
            uidx_reg    <= '0;
            init_reg    <= 1'b1;
            ch_vld_reg  <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
            case (state_reg)
                fpsa_pkg::S_IDLE:
                begin
                    if (acc)
                    begin
                        fidx_reg   <= '0;
                        uidx_reg   <= '0;
                        ch_vld_reg <= 1'b0;
                    end
                end
                fpsa_pkg::S_ACHK:
                begin
                    if (take)
                    begin
                        ch_vld_reg <= 1'b1;
                    end
                    fidx_reg <= fidx_reg + FONE;
                end
                fpsa_pkg::S_ADEC:
                begin
                    if (alloc_ok)
                    begin
                        ucnt_reg <= ucnt_reg + UONE;
                        if (ch_idx_reg == '0)
                        begin
                            init_reg <= 1'b0;
                        end
                    end
                end
                fpsa_pkg::S_FCHK:
                begin
                    if (u_match)
                    begin
                        if (fcnt_reg != FMAX)
                        begin
                            fcnt_reg <= fcnt_reg + FONE;
                        end
                    end
                    else
                    begin
                        uidx_reg <= uidx_p1;
                    end
                end
                fpsa_pkg::S_SRD:
                begin
                    if (uidx_p1 == ucnt_reg)
                    begin
                        ucnt_reg <= ucnt_reg - UONE;
                    end
                end
                fpsa_pkg::S_SWR:
                begin
                    uidx_reg <= uidx_p1;
                end
                default:
                begin
                    init_reg <= init_reg;
                end
            endcase
            if (cfg.pool_wr)
            begin
                fcnt_reg <= FONE;
                ucnt_reg <= '0;
                init_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fpsa_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    cmd_reg         <= command.cmd;
                    req_reg         <= command.req_size;
                    addr_reg        <= command.block_addr;
                    pend_status_reg <= fpsa_pkg::ST_NO_FIT;
                    pend_addr_reg   <= '0;
                end
            end
            fpsa_pkg::S_ACHK:
            begin
                if (take)
                begin
                    ch_idx_reg  <= fidx_reg[FIW-1:0];
                    ch_base_reg <= seg_base;
                    ch_len_reg  <= seg_len;
                end
            end
            fpsa_pkg::S_ADEC:
            begin
                if (!ch_vld_reg)
                begin
                    pend_status_reg <= fpsa_pkg::ST_NO_FIT;
                end
                else if (ucnt_reg == UMAX)
                begin
                    pend_status_reg <= fpsa_pkg::ST_FULL;
                end
                else
                begin
                    pend_status_reg <= fpsa_pkg::ST_OK;
                    pend_addr_reg   <= ch_base_reg;
                end
            end
            fpsa_pkg::S_FRD:
            begin
                if (uidx_reg == ucnt_reg)
                begin
                    pend_status_reg <= fpsa_pkg::ST_BAD_BASE;
                end
            end
            fpsa_pkg::S_FCHK:
            begin
                if (u_match)
                begin
                    pend_status_reg <= (fcnt_reg == FMAX) ? fpsa_pkg::ST_FULL : fpsa_pkg::ST_OK;
                end
            end
            fpsa_pkg::S_RESP:
            begin
                if (rsp_load)
                begin
                    rsp_status_reg <= pend_status_reg;
                    rsp_addr_reg   <= (cmd_reg == fpsa_pkg::CMD_ALLOC) ? pend_addr_reg : '0;
                end
            end
            default:
            begin
                pend_addr_reg <= pend_addr_reg;
            end
        endcase
    end

    assign result.valid        = rsp_vld_reg;
    assign result.status       = rsp_status_reg;
    assign result.granted_addr = rsp_addr_reg;

    a_ucnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ucnt_reg <= UMAX)
        else $error("allocated count beyond table depth");

    a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fcnt_reg != '0) && (fcnt_reg <= FMAX))
        else $error("free count out of range");

    a_pool_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.pool_wr |=> (fcnt_reg == FONE) && (ucnt_reg == '0) && init_reg)
        else $error("pool write did not reinitialise tables");

    a_rsp_load: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> rsp_vld_reg && (state_reg == fpsa_pkg::S_IDLE))
        else $error("result not presented after load");

endmodule

/* hw/rtl/fpsa_ram.sv */
// ============================================================================
// fpsa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
module fpsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/fpsa_regs.sv */
// ============================================================================
// fpsa_regs
// APB register file: pool size and fit policy.
// ============================================================================
module fpsa_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpsa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fpsa_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fpsa_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output fpsa_pkg::cfg_t                  cfg
);

    logic [fpsa_pkg::ADDR_BITS-1:0] pool_reg;
    logic [fpsa_pkg::POLICY_W-1:0]  policy_reg;
    logic                           wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg   <= fpsa_pkg::POOL_SIZE_RST;
            policy_reg <= fpsa_pkg::POL_FIRST;
        end
        else if (wr)
        begin
            if (paddr[2] == fpsa_pkg::REG_POOL_SIZE)
            begin
                pool_reg <= pwdata[fpsa_pkg::ADDR_BITS-1:0];
            end
            else
            begin
                policy_reg <= pwdata[fpsa_pkg::POLICY_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == fpsa_pkg::REG_POOL_SIZE)
        begin
            prdata = {{(fpsa_pkg::CFG_DATA_W-fpsa_pkg::ADDR_BITS){1'b0}}, pool_reg};
        end
        else
        begin
            prdata = {{(fpsa_pkg::CFG_DATA_W-fpsa_pkg::POLICY_W){1'b0}}, policy_reg};
        end
    end

    assign cfg.pool_size  = pool_reg;
    assign cfg.fit_policy = policy_reg;
    assign cfg.pool_wr    = wr && (paddr[2] == fpsa_pkg::REG_POOL_SIZE);

endmodule

/* bench/fit_policy_segment_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_policy_segment_allocator_tb
// Self-checking bench for the segment allocator. A directed table walks the
// corner cases (zero request, no fit, unknown base, full tables), then
// random allocate/free traffic runs under three idling patterns and several
// pool sizes and placement rules. Every result beat is checked against the
// row's typed value or else an in-bench model of the free and allocated tables.
// ----------------------------------------------------------------------------
module fit_policy_segment_allocator_tb;
    import fpsa_pkg::*;

    localparam int NFREE = 32;
    localparam int NUSED = 32;

    typedef struct {
        logic                 cmd;
        logic [ADDR_BITS-1:0] req_size;
        logic [ADDR_BITS-1:0] block_addr;
        logic                 typed_in;    // expected value given in the row
        status_t              exp_status;
        logic [ADDR_BITS-1:0] exp_addr;
    } cmd_row_t;

    typedef struct {
        status_t              status;
        logic [ADDR_BITS-1:0] granted_addr;
    } grant_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    fpsa_cmd_if command ();
    fpsa_rsp_if result ();

    fit_policy_segment_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command.sink),
        .result  (result.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block's tables and registers
    logic [ADDR_BITS-1:0] m_pool;
    logic [POLICY_W-1:0]  m_policy;
    logic [ADDR_BITS-1:0] m_fbase [NFREE];
    logic [ADDR_BITS-1:0] m_flen  [NFREE];
    int                   m_fcount;
    logic [ADDR_BITS-1:0] m_ubase [NUSED];
    logic [ADDR_BITS-1:0] m_ulen  [NUSED];
    int                   m_ucount;

    grant_t pending_grants[$];
    int     errors;
    int     send_idle_pct;
    int     recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // safety net: far beyond the slowest correct run
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void pool_reset(logic [ADDR_BITS-1:0] size);
        m_pool   = size;
        m_fcount = 1;
        m_ucount = 0;
        for (int i = 0; i < NFREE; i++)
        begin
            m_fbase[i] = '0;
            m_flen[i]  = '0;
        end
        m_flen[0] = size;
    endfunction

    // Works out the answer to one command and updates the shadow tables.
    function automatic grant_t place_or_release(logic cmd, logic [ADDR_BITS-1:0] req,
                                                logic [ADDR_BITS-1:0] addr);
        grant_t g;
        int     pick;
        int     hit;
        g.status       = ST_OK;
        g.granted_addr = '0;
        pick = -1;
        hit  = -1;
        if (cmd == CMD_ALLOC)
        begin
            if (req == 0 || m_policy > POL_WORST)
            begin
                g.status = ST_NO_FIT;
                return g;
            end
            for (int i = 0; i < m_fcount; i++)
            begin
                if (m_flen[i] < req)
                    continue;
                if (m_policy == POL_FIRST)
                begin
                    pick = i;
                    break;
                end
                if (pick < 0 || (m_policy == POL_BEST && m_flen[i] < m_flen[pick]) ||
                    (m_policy == POL_WORST && m_flen[i] > m_flen[pick]))
                    pick = i;
            end
            if (pick < 0)
                g.status = ST_NO_FIT;
            else if (m_ucount >= NUSED)
                g.status = ST_FULL;
            else
            begin
                g.granted_addr     = m_fbase[pick];
                m_ubase[m_ucount]  = m_fbase[pick];
                m_ulen[m_ucount]   = req;
                m_ucount++;
                m_fbase[pick] = m_fbase[pick] + req;
                m_flen[pick]  = m_flen[pick] - req;
            end
        end
        else
        begin
            for (int i = 0; i < m_ucount; i++)
                if (m_ubase[i] == addr)
                begin
                    hit = i;
                    break;
                end
            if (hit < 0)
                g.status = ST_BAD_BASE;
            else if (m_fcount >= NFREE)
                g.status = ST_FULL;
            else
            begin
                m_fbase[m_fcount] = m_ubase[hit];
                m_flen[m_fcount]  = m_ulen[hit];
                m_fcount++;
                for (int i = hit; i + 1 < m_ucount; i++)
                begin
                    m_ubase[i] = m_ubase[i + 1];
                    m_ulen[i]  = m_ulen[i + 1];
                end
                m_ucount--;
            end
        end
        return g;
    endfunction

    // APB write: setup then access; pready is tied high
    task automatic reg_write(logic reg_idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_POOL_SIZE)
            pool_reset(value[ADDR_BITS-1:0]);
        else
            m_policy = value[POLICY_W-1:0];
    endtask

    // wait for all results, then a settle pause before touching registers
    task automatic drain();
        command.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // One command beat. With a typed row the row's value is checked instead
    // of the model's; the model still runs so the tables stay in step.
    // valid stays up after a beat until the next beat or an idle cycle.
    task automatic send_cmd(cmd_row_t row);
        grant_t g;
        while ($urandom_range(99) < send_idle_pct)
        begin
            command.valid <= 1'b0;
            @(posedge clk);
        end
        command.valid      <= 1'b1;
        command.cmd        <= row.cmd;
        command.req_size   <= row.req_size;
        command.block_addr <= row.block_addr;
        @(posedge clk);
        while (!command.ready)
            @(posedge clk);
        g = place_or_release(row.cmd, row.req_size, row.block_addr);
        if (row.typed_in)
        begin
            g.status       = row.exp_status;
            g.granted_addr = row.exp_addr;
        end
        pending_grants.push_back(g);
    endtask

    function automatic cmd_row_t mk(logic cmd, int req, int addr, logic typed,
                                    status_t st, int ga);
        cmd_row_t r;
        r.cmd = cmd; r.req_size = ADDR_BITS'(req); r.block_addr = ADDR_BITS'(addr);
        r.typed_in = typed; r.exp_status = st; r.exp_addr = ADDR_BITS'(ga);
        return r;
    endfunction

    // receiver: random back-pressure, compare each beat with the oldest
    initial
    begin
        grant_t want;
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        errors++;
                    end
                    if (result.granted_addr !== want.granted_addr)
                    begin
                        $error("granted_addr: expected %0h, got %0h",
                               want.granted_addr, result.granted_addr);
                        errors++;
                    end
                end
            end
            result.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // random traffic: mostly allocations of modest size and frees of live
    // bases, with some unknown bases and the odd oversize request
    task automatic random_phase(int n, int max_req);
        cmd_row_t r;
        int       sel;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(99);
            if (sel < 50)
                r = mk(CMD_ALLOC, $urandom_range(max_req, 1), $urandom, 1'b0, ST_OK, 0);
            else if (sel < 85 && m_ucount > 0)
                r = mk(CMD_FREE, $urandom, m_ubase[$urandom_range(m_ucount - 1)], 1'b0,
                       ST_OK, 0);
            else
                r = mk(1'($urandom_range(1)), $urandom_range(16'hFFFF),
                       $urandom_range(16'hFFFF), 1'b0, ST_OK, 0);
            send_cmd(r);
        end
    endtask

    initial
    begin
        cmd_row_t rows[$];
        errors        = 0;
        send_idle_pct = 14;
        recv_idle_pct = 74;
        m_policy      = POL_FIRST;
        pool_reset(POOL_SIZE_RST);
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        command.valid      = 1'b0;
        command.cmd        = CMD_ALLOC;
        command.req_size   = '0;
        command.block_addr = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset pool of 4096, first fit
        rows.push_back(mk(CMD_ALLOC, 0, 0, 1'b1, ST_NO_FIT, 0));       // zero request
        rows.push_back(mk(CMD_ALLOC, 16'hFFFF, 0, 1'b1, ST_NO_FIT, 0)); // too big
        rows.push_back(mk(CMD_FREE, 0, 0, 1'b1, ST_BAD_BASE, 0));      // nothing allocated
        rows.push_back(mk(CMD_ALLOC, 100, 16'hFFFF, 1'b1, ST_OK, 0));
        rows.push_back(mk(CMD_ALLOC, 50, 0, 1'b1, ST_OK, 100));
        rows.push_back(mk(CMD_ALLOC, 30, 0, 1'b1, ST_OK, 150));
        rows.push_back(mk(CMD_FREE, 16'hFFFF, 100, 1'b1, ST_OK, 0));   // hole of 50
        rows.push_back(mk(CMD_FREE, 0, 100, 1'b1, ST_BAD_BASE, 0));    // already freed
        rows.push_back(mk(CMD_FREE, 0, 0, 1'b1, ST_OK, 0));            // hole of 100
        rows.push_back(mk(CMD_ALLOC, 3916, 0, 1'b1, ST_OK, 180));      // rest, leaves zero
        rows.push_back(mk(CMD_ALLOC, 40, 0, 1'b0, ST_OK, 0));
        rows.push_back(mk(CMD_ALLOC, 1, 0, 1'b0, ST_OK, 0));
        foreach (rows[i])
            send_cmd(rows[i]);
        drain();

        // best and worst fit over the same holes, then unused policy code
        for (int p = 1; p <= 3; p++)
        begin
            reg_write(REG_FIT_POLICY, p);
            send_cmd(mk(CMD_ALLOC, 20, 0, 1'b0, ST_OK, 0));
            send_cmd(mk(CMD_ALLOC, 20, 0, 1'b0, ST_OK, 0));
            drain();
        end

        // fill the allocated table, then fill the free table by freeing
        reg_write(REG_POOL_SIZE, 32'hFFFF_FFFF);
        reg_write(REG_FIT_POLICY, POL_FIRST);
        for (int i = 0; i < 34; i++)
            send_cmd(mk(CMD_ALLOC, 1, 0, 1'b0, ST_OK, 0));
        for (int i = 0; i < 33; i++)
            send_cmd(mk(CMD_FREE, 0, i, 1'b0, ST_OK, 0));
        drain();

        // pool of zero: every allocate misses
        reg_write(REG_POOL_SIZE, 0);
        send_cmd(mk(CMD_ALLOC, 1, 0, 1'b1, ST_NO_FIT, 0));
        drain();

        // random traffic over several settings and idling patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 74 : 0;
            recv_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 14 : 0;
            reg_write(REG_POOL_SIZE, (ph == 5) ? 1 : (ph == 1) ? 16'hFFFF :
                      $urandom_range(4096, 64));
            reg_write(REG_FIT_POLICY, ph % 3);
            random_phase(100, (ph == 1) ? 16'hFFFF : 200);
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/fpsa_pkg.sv
hw/rtl/fpsa_if.sv
hw/rtl/fpsa_ram.sv
hw/rtl/fpsa_regs.sv
hw/rtl/fit_policy_segment_allocator.sv
bench/fit_policy_segment_allocator_tb.sv
